### rtl/core/txcw_pkg.sv
// ----------------------------------------------------------------------------
// txcw_pkg
// Shared constants, command codes and the digit glyph function of the text
// console cell writer.
// ----------------------------------------------------------------------------
package txcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam int MODE_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int IN_ROW_W  = 5;
  localparam int IN_COL_W  = 7;
  localparam int VALUE_W   = 32;
  localparam int RADIX_W   = 5;
  localparam int INDEX_W   = 11;
  localparam int WORD_W    = 16;
  localparam int DIGIT_W   = 4;
  localparam int MAX_DIGITS = 32;
  localparam int PTR_W     = $clog2(MAX_DIGITS);
  localparam int STEP_W    = $clog2(VALUE_W);

  localparam logic [MODE_W-1:0] MODE_PUT_CHAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BACKSPACE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOVE      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NUMBER    = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_LINE_FEED = 8'h0A;
  localparam logic [WORD_W-1:0] BLANK_WORD     = 16'h0020;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  // Maps a digit value to its character: 0-9, then A-F.
  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] g;
    if (d < 4'd10) begin
      g = 8'h30 + {4'd0, d};
    end else begin
      g = 8'h37 + {4'd0, d};
    end
    return g;
  endfunction

endpackage

### rtl/core/txcw_divider.sv
// ----------------------------------------------------------------------------
// txcw_divider
// Restoring radix divider, one quotient bit per cycle. A start pulse loads
// the dividend and divisor; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module txcw_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [txcw_pkg::VALUE_W-1:0]  dividend,
  input  logic [txcw_pkg::RADIX_W-1:0]  divisor,
  output logic                          done,
  output logic [txcw_pkg::VALUE_W-1:0]  quotient,
  output logic [txcw_pkg::DIGIT_W-1:0]  remainder
);
  import txcw_pkg::*;

  logic                 busy;
  logic [STEP_W-1:0]    step;
  logic [RADIX_W-1:0]   div_reg;
  logic [VALUE_W-1:0]   quo;
  logic [DIGIT_W-1:0]   rem;
  logic [RADIX_W-1:0]   trial;
  logic                 fits;

  // The remainder stays below the divisor (at most 16), so the shifted
  // trial value always fits in five bits.
  assign trial = {rem, quo[VALUE_W-1]};
  assign fits  = (trial >= div_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(VALUE_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= dividend;
      rem     <= '0;
      div_reg <= divisor;
    end else if (busy) begin
      quo <= {quo[VALUE_W-2:0], fits};
      if (fits) begin
        rem <= DIGIT_W'(trial - div_reg);
      end else begin
        rem <= trial[DIGIT_W-1:0];
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### rtl/core/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text console writer: keeps a cursor and turns commands into screen cell
// writes (cell index and attribute/character word).
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_stall) carries one command item: put char,
// backspace, move cursor or print number. The output channel
// (out_valid/out_stall) carries one item per cell write, with last set on
// the final write caused by a command. Move cursor and a line feed produce
// no output item.
// Commands are handled one at a time; in_stall is high while a command is
// in progress. Print number runs one divider, one quotient bit per cycle,
// once for each digit, then writes one digit per cycle while the output
// is not stalled.
// A stall on the output holds the output register and pauses the digit
// writes. All digits are divided out before the first one is written.
// Reset (rst, synchronous) puts the cursor at the top left cell and empties
// the output register.
// ----------------------------------------------------------------------------
module text_console_cell_writer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [txcw_pkg::MODE_W-1:0]    mode,
  input  logic [txcw_pkg::CHAR_W-1:0]    char_code,
  input  logic [txcw_pkg::ATTR_W-1:0]    attribute,
  input  logic [txcw_pkg::IN_ROW_W-1:0]  row,
  input  logic [txcw_pkg::IN_COL_W-1:0]  column,
  input  logic [txcw_pkg::VALUE_W-1:0]   value,
  input  logic [txcw_pkg::RADIX_W-1:0]   radix,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [txcw_pkg::INDEX_W-1:0]   cell_index,
  output logic [txcw_pkg::WORD_W-1:0]    cell_word,
  output logic                           last
);
  import txcw_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHAR = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]          state;
  logic [ROW_W-1:0]    cur_row;
  logic [COL_W-1:0]    cur_col;
  logic [ATTR_W-1:0]   attr_reg;
  logic [WORD_W-1:0]   char_word;
  logic                char_adv;
  logic [RADIX_W-1:0]  radix_reg;
  logic [PTR_W-1:0]    cnt;
  logic [PTR_W-1:0]    ptr;
  logic [DIGIT_W-1:0]  digits [MAX_DIGITS];

  logic                accept;
  logic                out_free;
  logic                at_last_col;
  logic                at_last_row;
  logic [ROW_W-1:0]    row_down;
  logic [ROW_W-1:0]    fwd_row;
  logic [COL_W-1:0]    fwd_col;
  logic [ROW_W-1:0]    back_row;
  logic [COL_W-1:0]    back_col;
  logic [ROW_W-1:0]    move_row;
  logic [COL_W-1:0]    move_col;
  logic [RADIX_W-1:0]  radix_sat;
  logic [31:0]         index_full;

  logic                div_start;
  logic [VALUE_W-1:0]  div_dividend;
  logic [RADIX_W-1:0]  div_divisor;
  logic                div_done;
  logic [VALUE_W-1:0]  div_quotient;
  logic [DIGIT_W-1:0]  div_remainder;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Cursor arithmetic on separate row and column counters.
  assign at_last_col = (cur_col == COL_W'(COLUMNS - 1));
  assign at_last_row = (cur_row == ROW_W'(ROWS - 1));
  assign row_down    = at_last_row ? '0 : cur_row + 1'b1;
  assign fwd_col     = at_last_col ? '0 : cur_col + 1'b1;
  assign fwd_row     = at_last_col ? row_down : cur_row;

  always_comb begin
    if (cur_col == '0) begin
      back_col = COL_W'(COLUMNS - 1);
      back_row = (cur_row == '0) ? ROW_W'(ROWS - 1) : cur_row - 1'b1;
    end else begin
      back_col = cur_col - 1'b1;
      back_row = cur_row;
    end
  end

  always_comb begin
    if (32'(row) >= 32'(ROWS)) begin
      move_row = ROW_W'(ROWS - 1);
    end else begin
      move_row = ROW_W'(row);
    end
    if (32'(column) >= 32'(COLUMNS)) begin
      move_col = COL_W'(COLUMNS - 1);
    end else begin
      move_col = COL_W'(column);
    end
  end

  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = radix;
    end
  end

  assign index_full = 32'(cur_row) * 32'(COLUMNS) + 32'(cur_col);

  // The divider is started from the input item for the first digit and from
  // its own quotient for each later digit.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = div_quotient;
    div_divisor  = radix_reg;
    if (state == S_IDLE) begin
      div_dividend = value;
      div_divisor  = radix_sat;
      div_start    = accept && (mode == MODE_NUMBER);
    end else if (state == S_DIV) begin
      div_start = div_done && (div_quotient != '0) && (cnt != PTR_W'(MAX_DIGITS - 1));
    end
  end

  txcw_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // Sequencer and cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cur_row <= '0;
      cur_col <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (mode)
              MODE_PUT_CHAR: begin
                if (char_code == CHAR_LINE_FEED) begin
                  cur_col <= '0;
                  cur_row <= row_down;
                end else begin
                  state <= S_CHAR;
                end
              end
              MODE_BACKSPACE: begin
                cur_row <= back_row;
                cur_col <= back_col;
                state   <= S_CHAR;
              end
              MODE_MOVE: begin
                cur_row <= move_row;
                cur_col <= move_col;
              end
              MODE_NUMBER: begin
                state <= S_DIV;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_CHAR: begin
          if (out_free) begin
            if (char_adv) begin
              cur_row <= fwd_row;
              cur_col <= fwd_col;
            end
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done && !div_start) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            cur_row <= fwd_row;
            cur_col <= fwd_col;
            if (ptr == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command payload and digit buffer.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      attr_reg  <= attribute;
      radix_reg <= radix_sat;
      cnt       <= '0;
      char_adv  <= (mode == MODE_PUT_CHAR);
      if (mode == MODE_BACKSPACE) begin
        char_word <= BLANK_WORD;
      end else begin
        char_word <= {attribute, char_code};
      end
    end
    if (state == S_DIV && div_done) begin
      digits[cnt] <= div_remainder;
      cnt         <= cnt + 1'b1;
      ptr         <= cnt;
    end else if (state == S_EMIT && out_free) begin
      ptr <= ptr - 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= (state == S_CHAR) || (state == S_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      cell_index <= index_full[INDEX_W-1:0];
      if (state == S_EMIT) begin
        cell_word <= {attr_reg, digit_glyph(digits[ptr])};
        last      <= (ptr == '0);
      end else begin
        cell_word <= char_word;
        last      <= 1'b1;
      end
    end
  end

endmodule

### verif/text_console_cell_writer_tb.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_tb
// Self-checking testbench for the text console cell writer. A cursor model
// predicts the cell writes of every accepted command. The checker compares
// each written cell, field by field, with the oldest prediction. Directed
// commands cover the screen edges, the line feed, backspace wrap, move
// saturation and number printing in every radix range. Random commands then
// run with random idle bursts on both channels, a long output hold-off and
// full-rate stretches.
// ----------------------------------------------------------------------------
module text_console_cell_writer_tb;
  import txcw_pkg::*;

  localparam int CELL_COUNT  = COLUMNS * ROWS;
  localparam int RESET_LEN   = 6;
  localparam int HOLD_LEN    = 400;
  localparam int DRAIN_SLACK = 40;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [CHAR_W-1:0]   char_code;
    logic [ATTR_W-1:0]   attribute;
    logic [IN_ROW_W-1:0] row;
    logic [IN_COL_W-1:0] column;
    logic [VALUE_W-1:0]  value;
    logic [RADIX_W-1:0]  radix;
  } console_cmd_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  word;
    logic               last;
  } cell_write_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [MODE_W-1:0]   mode;
  logic [CHAR_W-1:0]   char_code;
  logic [ATTR_W-1:0]   attribute;
  logic [IN_ROW_W-1:0] row;
  logic [IN_COL_W-1:0] column;
  logic [VALUE_W-1:0]  value;
  logic [RADIX_W-1:0]  radix;
  logic out_valid;
  logic out_stall;
  logic [INDEX_W-1:0] cell_index;
  logic [WORD_W-1:0]  cell_word;
  logic last;

  cell_write_t expected_writes[$];
  int cursor_model;
  int mismatch_count;
  int cycle_count;
  bit sender_idle;
  bit receiver_idle;
  bit hold_request;

  text_console_cell_writer uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .char_code  (char_code),
    .attribute  (attribute),
    .row        (row),
    .column     (column),
    .value      (value),
    .radix      (radix),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_index (cell_index),
    .cell_word  (cell_word),
    .last       (last)
  );

  always #6 clk = ~clk;

  // Works out the cell writes of one command and moves the cursor model.
  task automatic predict_cell_writes(input console_cmd_t c);
    logic [CHAR_W-1:0] glyphs[$];
    logic [CHAR_W-1:0] glyph;
    cell_write_t w;
    int unsigned rest;
    int unsigned base;
    int unsigned d;
    int row_sat;
    int col_sat;
    case (c.mode)
      MODE_PUT_CHAR: begin
        if (c.char_code == CHAR_LINE_FEED) begin
          cursor_model = (cursor_model / COLUMNS + 1) * COLUMNS;
          if (cursor_model >= CELL_COUNT) begin
            cursor_model = 0;
          end
        end else begin
          glyphs.push_back(c.char_code);
        end
      end
      MODE_BACKSPACE: begin
        cursor_model = (cursor_model == 0) ? CELL_COUNT - 1 : cursor_model - 1;
        w.index = cursor_model[INDEX_W-1:0];
        w.word  = BLANK_WORD;
        w.last  = 1'b1;
        expected_writes.push_back(w);
      end
      MODE_MOVE: begin
        row_sat = (c.row > ROWS - 1) ? ROWS - 1 : int'(c.row);
        col_sat = (c.column > COLUMNS - 1) ? COLUMNS - 1 : int'(c.column);
        cursor_model = row_sat * COLUMNS + col_sat;
      end
      default: begin
        base = 32'(c.radix);
        if (base < RADIX_MIN) begin
          base = 32'(RADIX_MIN);
        end
        if (base > RADIX_MAX) begin
          base = 32'(RADIX_MAX);
        end
        rest = c.value;
        // Digits come out least significant first, so each one goes in front.
        do begin
          d = rest % base;
          glyph = (d < 10) ? 8'(8'h30 + d) : 8'(8'h41 + d - 10);
          glyphs.push_front(glyph);
          rest = rest / base;
        end while (rest != 0 && glyphs.size() < MAX_DIGITS);
      end
    endcase
    foreach (glyphs[i]) begin
      w.index = cursor_model[INDEX_W-1:0];
      w.word  = {c.attribute, glyphs[i]};
      w.last  = (i == glyphs.size() - 1);
      expected_writes.push_back(w);
      cursor_model = (cursor_model + 1) % CELL_COUNT;
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Offers one item, waits until it is taken and records its cell writes.
  task automatic send_item(input console_cmd_t c);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= c.mode;
    char_code <= c.char_code;
    attribute <= c.attribute;
    row       <= c.row;
    column    <= c.column;
    value     <= c.value;
    radix     <= c.radix;
    do begin
      @(posedge clk);
    end while (in_stall);
    predict_cell_writes(c);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_writes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic console_cmd_t make_command(
    input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] ch,
    input logic [ATTR_W-1:0] attr, input logic [IN_ROW_W-1:0] r,
    input logic [IN_COL_W-1:0] col, input logic [VALUE_W-1:0] val,
    input logic [RADIX_W-1:0] base);
    console_cmd_t c;
    c.mode      = m;
    c.char_code = ch;
    c.attribute = attr;
    c.row       = r;
    c.column    = col;
    c.value     = val;
    c.radix     = base;
    return c;
  endfunction

  // Mostly well-formed commands; unused fields carry random bits.
  function automatic console_cmd_t random_command();
    console_cmd_t c;
    int pick;
    c.char_code = CHAR_W'($urandom_range(0, 255));
    c.attribute = ATTR_W'($urandom_range(0, 255));
    c.row       = IN_ROW_W'($urandom_range(0, 31));
    c.column    = IN_COL_W'($urandom_range(0, 127));
    c.value     = $urandom >> $urandom_range(0, 31);
    c.radix     = RADIX_W'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c.mode = MODE_PUT_CHAR;
      if ($urandom_range(0, 9) == 0) begin
        c.char_code = CHAR_LINE_FEED;
      end
    end else if (pick < 55) begin
      c.mode = MODE_BACKSPACE;
    end else if (pick < 70) begin
      c.mode = MODE_MOVE;
      if ($urandom_range(0, 4) != 0) begin
        c.row    = IN_ROW_W'($urandom_range(0, ROWS - 1));
        c.column = IN_COL_W'($urandom_range(0, COLUMNS - 1));
      end
    end else begin
      c.mode = MODE_NUMBER;
      if ($urandom_range(0, 4) != 0) begin
        c.radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
      end
      if ($urandom_range(0, 9) == 0) begin
        c.value = '0;
      end
    end
    return c;
  endfunction

  task automatic test_put_char();
    send_item(make_command(MODE_MOVE, 8'h00, 8'h00, 5'd0, 7'd0, 32'd0, 5'd0));
    send_item(make_command(MODE_PUT_CHAR, 8'h41, 8'h1F, 5'd0, 7'd0, 32'd0, 5'd0));
    send_item(make_command(MODE_PUT_CHAR, 8'h00, 8'h00, 5'd0, 7'd0, 32'd0, 5'd0));
    send_item(make_command(MODE_PUT_CHAR, 8'hFF, 8'hFF, 5'd31, 7'd127, '1, 5'd31));
    send_item(make_command(MODE_PUT_CHAR, CHAR_LINE_FEED, 8'h07, 5'd0, 7'd0, 32'd0, 5'd0));
    // A line feed on the bottom row goes back to the top left cell.
    send_item(make_command(MODE_MOVE, 8'h00, 8'h00, 5'd24, 7'd0, 32'd0, 5'd0));
    send_item(make_command(MODE_PUT_CHAR, CHAR_LINE_FEED, 8'h00, 5'd0, 7'd0, 32'd0, 5'd0));
    send_item(make_command(MODE_MOVE, 8'h00, 8'h00, 5'd24, 7'd79, 32'd0, 5'd0));
    send_item(make_command(MODE_PUT_CHAR, CHAR_LINE_FEED, 8'h00, 5'd0, 7'd0, 32'd0, 5'd0));
    wait_until_drained();
  endtask

  task automatic test_backspace();
    send_item(make_command(MODE_BACKSPACE, 8'h55, 8'hAA, 5'd0, 7'd0, 32'd0, 5'd0));
    send_item(make_command(MODE_MOVE, 8'h00, 8'h00, 5'd0, 7'd0, 32'd0, 5'd0));
    send_item(make_command(MODE_BACKSPACE, 8'hFF, 8'hFF, 5'd31, 7'd127, '1, 5'd31));
    // The cursor now sits on the last cell, so the next write lands there and the cursor wraps to zero.
    send_item(make_command(MODE_PUT_CHAR, 8'h5A, 8'h4E, 5'd0, 7'd0, 32'd0, 5'd0));
    wait_until_drained();
  endtask

  task automatic test_move();
    send_item(make_command(MODE_MOVE, 8'h00, 8'h00, 5'd31, 7'd127, 32'd0, 5'd0));
    send_item(make_command(MODE_PUT_CHAR, 8'h21, 8'h70, 5'd0, 7'd0, 32'd0, 5'd0));
    send_item(make_command(MODE_MOVE, 8'h00, 8'h00, 5'd12, 7'd100, 32'd0, 5'd0));
    send_item(make_command(MODE_PUT_CHAR, 8'h7E, 8'h0F, 5'd0, 7'd0, 32'd0, 5'd0));
    wait_until_drained();
  endtask

  task automatic test_print_number();
    send_item(make_command(MODE_NUMBER, 8'h00, 8'h02, 5'd0, 7'd0, 32'd0, 5'd10));
    send_item(make_command(MODE_NUMBER, 8'h00, 8'hFF, 5'd0, 7'd0, 32'hFFFFFFFF, 5'd2));
    send_item(make_command(MODE_NUMBER, 8'h00, 8'h1E, 5'd0, 7'd0, 32'hFFFFFFFF, 5'd16));
    send_item(make_command(MODE_NUMBER, 8'h00, 8'h00, 5'd0, 7'd0, 32'hDEADBEEF, 5'd0));
    send_item(make_command(MODE_NUMBER, 8'h00, 8'h33, 5'd0, 7'd0, 32'd12345, 5'd1));
    send_item(make_command(MODE_NUMBER, 8'h00, 8'h44, 5'd0, 7'd0, 32'h89ABCDEF, 5'd31));
    send_item(make_command(MODE_NUMBER, 8'h00, 8'h55, 5'd0, 7'd0, 32'hFFFFFFFF, 5'd10));
    send_item(make_command(MODE_NUMBER, 8'h00, 8'h66, 5'd0, 7'd0, 32'd100, 5'd17));
    // A long number written near the end of the screen wraps to the top.
    send_item(make_command(MODE_MOVE, 8'h00, 8'h00, 5'd24, 7'd78, 32'd0, 5'd0));
    send_item(make_command(MODE_NUMBER, 8'h00, 8'h0C, 5'd0, 7'd0, 32'hFFFFFFFF, 5'd2));
    wait_until_drained();
  endtask

  // The output is held off while commands keep coming, so the input backs up.
  task automatic test_receiver_hold();
    hold_request = 1'b1;
    repeat (12) begin
      send_item(random_command());
    end
    wait_until_drained();
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 3 || i == count - 30) begin
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
      end else if (i == count / 3 + 30) begin
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
      end
      if (i == count / 2) begin
        wait_until_drained();
      end
      send_item(random_command());
    end
    wait_until_drained();
  endtask

  // Output side: random stall bursts and, on request, one long hold-off.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cell_write_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write: index %0d word %h last %b",
                                  cell_index, cell_word, last));
      end else begin
        want = expected_writes.pop_front();
        if (cell_index !== want.index) begin
          report_mismatch($sformatf("cell_index expected %0d got %0d",
                                    want.index, cell_index));
        end
        if (cell_word !== want.word) begin
          report_mismatch($sformatf("cell_word at %0d expected %h got %h",
                                    want.index, want.word, cell_word));
        end
        if (last !== want.last) begin
          report_mismatch($sformatf("last at %0d expected %b got %b",
                                    want.index, want.last, last));
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("** text_console_cell_writer: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    mismatch_count = 0;
    cursor_model   = 0;
    sender_idle    = 1'b1;
    receiver_idle  = 1'b1;
    hold_request   = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    mode      <= MODE_PUT_CHAR;
    char_code <= '0;
    attribute <= '0;
    row       <= '0;
    column    <= '0;
    value     <= '0;
    radix     <= '0;
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_put_char();
    test_backspace();
    test_move();
    test_print_number();
    test_receiver_hold();
    test_random_traffic(195);
    repeat (DRAIN_SLACK) @(posedge clk);
    if (mismatch_count == 0 && expected_writes.size() == 0) begin
      $display("** text_console_cell_writer: PASSED **");
    end else begin
      $display("** text_console_cell_writer: FAILED **");
    end
    $finish;
  end

endmodule
